// ----- rtl/core/owpi_pkg.sv -----
// Shared types, constants and widths for the omni wheel PI controller.
package owpi_pkg;

    // Default number of fraction bits in the PI gains.
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Field and register widths.
    localparam int VEL_W   = 9;
    localparam int MAP_W   = 10;
    localparam int ROT_W   = 12;
    localparam int ENC_W   = 16;
    localparam int DRV_W   = 11;
    localparam int TGT_W   = 16;
    localparam int INT_W   = 32;
    localparam int ERR_W   = 17;
    localparam int GAIN_W  = 12;
    localparam int RATIO_W = 16;
    localparam int LIM_W   = 10;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SQ_W    = 32;
    localparam int SQ_STEPS = 16;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  KP_RST    = 12'd640;
    localparam logic [GAIN_W-1:0]  KI_RST    = 12'd154;
    localparam logic [RATIO_W-1:0] RATIO_RST = 16'd256;
    localparam logic [LIM_W-1:0]   LIM_RST   = 10'd499;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_KP    = 2'd0;
    localparam logic [IDX_W-1:0] REG_KI    = 2'd1;
    localparam logic [IDX_W-1:0] REG_RATIO = 2'd2;
    localparam logic [IDX_W-1:0] REG_LIM   = 2'd3;

    // Fixed-point constants: cos 45 degrees in Q16 and 0.1 in Q26.
    localparam logic signed [MUL_B_W-1:0] COS45_Q16 = 24'sd46341;
    localparam logic signed [MUL_B_W-1:0] TENTH_Q26 = 24'sd6710886;
    localparam int TARGET_SHIFT = 26;
    localparam int MAP_SHIFT    = 15;

    // Function codes.
    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT,
        ST_SQ_INIT,
        ST_SQ_STEP,
        ST_SQ_MUL,
        ST_SQ_STORE,
        ST_TG_MUL1,
        ST_TG_MUL2,
        ST_TG_STORE,
        ST_PI_ERR,
        ST_PI_MULI,
        ST_PI_INTEG,
        ST_PI_MULP,
        ST_PI_DRIVE,
        ST_FINISH
    } t_state;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROT,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_SQ_MUL,
        OP_SQ_STORE,
        OP_TG_MUL1,
        OP_TG_MUL2,
        OP_TG_STORE,
        OP_PI_ERR,
        OP_PI_MULI,
        OP_PI_INTEG,
        OP_PI_MULP,
        OP_PI_DRIVE,
        OP_PUBLISH
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_op        op;
        logic       axis;
        logic [1:0] wheel;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic circle;
        logic out_busy;
    } t_stat;

endpackage

// ----- rtl/core/owpi_ctrl.sv -----
// Sequencing state machine for the omni wheel PI controller.
module owpi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_func,
    input  owpi_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output owpi_pkg::t_cmd  o_cmd
);

    owpi_pkg::t_state r_state, n_state;
    logic [3:0]       r_step, n_step;
    logic [1:0]       r_wheel, n_wheel;
    logic             r_axis, n_axis;

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= owpi_pkg::ST_IDLE;
            r_step  <= '0;
            r_wheel <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_wheel <= n_wheel;
            r_axis  <= n_axis;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_wheel    = r_wheel;
        n_axis     = r_axis;
        o_in_ready = 1'b0;
        o_cmd.op    = owpi_pkg::OP_NONE;
        o_cmd.axis  = r_axis;
        o_cmd.wheel = r_wheel;
        case (r_state)
            owpi_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                n_wheel    = '0;
                n_axis     = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = owpi_pkg::OP_LOAD;
                    n_state  = (i_func == owpi_pkg::FUNC_TICK) ? owpi_pkg::ST_PI_ERR
                                                               : owpi_pkg::ST_ROT;
                end
            end
            owpi_pkg::ST_ROT: begin
                o_cmd.op = owpi_pkg::OP_ROT;
                n_state  = i_stat.circle ? owpi_pkg::ST_SQ_INIT : owpi_pkg::ST_TG_MUL1;
            end
            owpi_pkg::ST_SQ_INIT: begin
                o_cmd.op = owpi_pkg::OP_SQ_INIT;
                n_step   = '0;
                n_state  = owpi_pkg::ST_SQ_STEP;
            end
            owpi_pkg::ST_SQ_STEP: begin
                o_cmd.op = owpi_pkg::OP_SQ_STEP;
                n_step   = r_step + 4'd1;
                if (r_step == 4'(owpi_pkg::SQ_STEPS - 1)) begin
                    n_state = owpi_pkg::ST_SQ_MUL;
                end
            end
            owpi_pkg::ST_SQ_MUL: begin
                o_cmd.op = owpi_pkg::OP_SQ_MUL;
                n_state  = owpi_pkg::ST_SQ_STORE;
            end
            owpi_pkg::ST_SQ_STORE: begin
                o_cmd.op = owpi_pkg::OP_SQ_STORE;
                n_axis   = 1'b1;
                n_state  = r_axis ? owpi_pkg::ST_TG_MUL1 : owpi_pkg::ST_SQ_INIT;
            end
            owpi_pkg::ST_TG_MUL1: begin
                o_cmd.op = owpi_pkg::OP_TG_MUL1;
                n_state  = owpi_pkg::ST_TG_MUL2;
            end
            owpi_pkg::ST_TG_MUL2: begin
                o_cmd.op = owpi_pkg::OP_TG_MUL2;
                n_state  = owpi_pkg::ST_TG_STORE;
            end
            owpi_pkg::ST_TG_STORE: begin
                o_cmd.op = owpi_pkg::OP_TG_STORE;
                n_wheel  = r_wheel + 2'd1;
                n_state  = (r_wheel == 2'd3) ? owpi_pkg::ST_IDLE : owpi_pkg::ST_TG_MUL1;
            end
            owpi_pkg::ST_PI_ERR: begin
                o_cmd.op = owpi_pkg::OP_PI_ERR;
                n_state  = owpi_pkg::ST_PI_MULI;
            end
            owpi_pkg::ST_PI_MULI: begin
                o_cmd.op = owpi_pkg::OP_PI_MULI;
                n_state  = owpi_pkg::ST_PI_INTEG;
            end
            owpi_pkg::ST_PI_INTEG: begin
                o_cmd.op = owpi_pkg::OP_PI_INTEG;
                n_state  = owpi_pkg::ST_PI_MULP;
            end
            owpi_pkg::ST_PI_MULP: begin
                o_cmd.op = owpi_pkg::OP_PI_MULP;
                n_state  = owpi_pkg::ST_PI_DRIVE;
            end
            owpi_pkg::ST_PI_DRIVE: begin
                o_cmd.op = owpi_pkg::OP_PI_DRIVE;
                n_wheel  = r_wheel + 2'd1;
                n_state  = (r_wheel == 2'd3) ? owpi_pkg::ST_FINISH : owpi_pkg::ST_PI_ERR;
            end
            owpi_pkg::ST_FINISH: begin
                // Wait until the output register is free.
                if (!i_stat.out_busy) begin
                    o_cmd.op = owpi_pkg::OP_PUBLISH;
                    n_state  = owpi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = owpi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/owpi_dp.sv -----
// Datapath: registers, shared multiplier, square root and PI arithmetic.
module owpi_dp #(
    parameter int GAIN_FRAC_BITS = owpi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  owpi_pkg::t_cmd                         i_cmd,
    output owpi_pkg::t_stat                        o_stat,
    input  logic                                   i_cfg_valid,
    input  logic [owpi_pkg::IDX_W-1:0]             i_cfg_index,
    input  logic [owpi_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic signed [owpi_pkg::VEL_W-1:0]      i_vel_x,
    input  logic signed [owpi_pkg::VEL_W-1:0]      i_vel_y,
    input  logic signed [owpi_pkg::ROT_W-1:0]      i_vel_rot,
    input  logic                                   i_circle_mode,
    input  logic signed [owpi_pkg::ENC_W-1:0]      i_enc_count_0,
    input  logic signed [owpi_pkg::ENC_W-1:0]      i_enc_count_1,
    input  logic signed [owpi_pkg::ENC_W-1:0]      i_enc_count_2,
    input  logic signed [owpi_pkg::ENC_W-1:0]      i_enc_count_3,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [owpi_pkg::DRV_W-1:0]      o_drive_0,
    output logic signed [owpi_pkg::DRV_W-1:0]      o_drive_1,
    output logic signed [owpi_pkg::DRV_W-1:0]      o_drive_2,
    output logic signed [owpi_pkg::DRV_W-1:0]      o_drive_3
);

    localparam int SUM_W = 34;
    localparam logic signed [SUM_W-1:0] DRV_BIAS = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // Configuration registers.
    logic [owpi_pkg::GAIN_W-1:0]  r_kp, r_ki;
    logic [owpi_pkg::RATIO_W-1:0] r_ratio;
    logic [owpi_pkg::LIM_W-1:0]   r_lim;

    // Item registers.
    logic signed [owpi_pkg::VEL_W-1:0] r_x, r_y;
    logic signed [owpi_pkg::MAP_W-1:0] r_mx, r_my;
    logic signed [owpi_pkg::ROT_W-1:0] r_rot;
    logic                              r_circle;
    logic signed [owpi_pkg::ENC_W-1:0] r_enc [4];

    // Wheel state.
    logic signed [owpi_pkg::TGT_W-1:0] r_target [4];
    logic signed [owpi_pkg::INT_W-1:0] r_integ  [4];

    // Working registers.
    logic signed [owpi_pkg::PROD_W-1:0] r_prod;
    logic signed [35:0]                 r_rotp;
    logic signed [owpi_pkg::ERR_W-1:0]  r_err;
    logic [30:0]                        r_sq_a;
    logic [owpi_pkg::SQ_W-1:0]          r_sq_r;
    logic [30:0]                        r_sq_bit;
    logic signed [owpi_pkg::DRV_W-1:0]  r_drive [4];
    logic signed [owpi_pkg::DRV_W-1:0]  r_out [4];
    logic                               r_out_valid;

    // Shared multiplier.
    logic signed [owpi_pkg::MUL_A_W-1:0] mul_a;
    logic signed [owpi_pkg::MUL_B_W-1:0] mul_b;
    logic signed [owpi_pkg::PROD_W-1:0]  mul_p;

    // Combinational helpers.
    logic signed [owpi_pkg::MAP_W:0]   s_sum;
    logic signed [owpi_pkg::MAP_W:0]   s_xt, s_yt;
    logic signed [owpi_pkg::VEL_W-1:0] sq_other;
    logic signed [17:0]                sq_osq;
    logic signed [32:0]                sq_diff;
    logic [owpi_pkg::SQ_W-1:0]         sq_rb;
    logic signed [owpi_pkg::PROD_W-1:0] map_b;
    logic signed [47:0]                tg_n, tg_b, tg_q;
    logic signed [owpi_pkg::TGT_W-1:0] tg_val;
    logic signed [SUM_W-1:0]           pi_sum, pi_b, pi_d, pi_lim;
    logic signed [owpi_pkg::INT_W-1:0] integ_sat;
    logic signed [owpi_pkg::DRV_W-1:0] drv_val;
    logic signed [owpi_pkg::TGT_W-1:0] cur_t;
    logic signed [owpi_pkg::INT_W-1:0] cur_i;

    assign cur_t = r_target[i_cmd.wheel];
    assign cur_i = r_integ[i_cmd.wheel];

    // Wheel sign pattern: x is negated on wheels 1 and 2, y on wheels 2 and 3.
    always_comb begin
        s_xt = (i_cmd.wheel == 2'd1 || i_cmd.wheel == 2'd2) ? -(11'(r_mx)) : 11'(r_mx);
        s_yt = i_cmd.wheel[1] ? -(11'(r_my)) : 11'(r_my);
        s_sum = s_xt + s_yt;
    end

    // Operand selection for the multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            owpi_pkg::OP_ROT: begin
                mul_a = owpi_pkg::MUL_A_W'(r_rot);
                mul_b = owpi_pkg::TENTH_Q26;
            end
            owpi_pkg::OP_SQ_MUL: begin
                mul_a = i_cmd.axis ? owpi_pkg::MUL_A_W'(r_y) : owpi_pkg::MUL_A_W'(r_x);
                mul_b = $signed({7'b0, r_sq_r[16:0]});
            end
            owpi_pkg::OP_TG_MUL1: begin
                mul_a = $signed({12'b0, r_ratio});
                mul_b = owpi_pkg::MUL_B_W'(s_sum);
            end
            owpi_pkg::OP_TG_MUL2: begin
                mul_a = r_prod[owpi_pkg::MUL_A_W-1:0];
                mul_b = owpi_pkg::COS45_Q16;
            end
            owpi_pkg::OP_PI_MULI: begin
                mul_a = owpi_pkg::MUL_A_W'(r_err);
                mul_b = $signed({12'b0, r_ki});
            end
            owpi_pkg::OP_PI_MULP: begin
                mul_a = owpi_pkg::MUL_A_W'(r_err);
                mul_b = $signed({12'b0, r_kp});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = owpi_pkg::PROD_W'(mul_a) * owpi_pkg::PROD_W'(mul_b);
    end

    // Square root argument, one restoring step, and the mapped value.
    always_comb begin
        sq_other = i_cmd.axis ? r_x : r_y;
        sq_osq   = 18'(sq_other) * 18'(sq_other);
        sq_diff  = (33'sd1 <<< 30) - (33'(sq_osq) <<< 15);
        sq_rb    = r_sq_r + {1'b0, r_sq_bit};
        map_b    = r_prod + ((r_prod < 0) ? owpi_pkg::PROD_W'((1 << owpi_pkg::MAP_SHIFT) - 1)
                                          : '0);
    end

    // Target from the scaled sum, truncated toward zero and saturated.
    always_comb begin
        tg_n = r_prod[47:0] - 48'(r_rotp);
        tg_b = tg_n + ((tg_n < 0) ? 48'((64'd1 << owpi_pkg::TARGET_SHIFT) - 64'd1) : 48'd0);
        tg_q = tg_b >>> owpi_pkg::TARGET_SHIFT;
        if (tg_q > 48'sd32767) begin
            tg_val = 16'sh7fff;
        end else if (tg_q < -48'sd32768) begin
            tg_val = -16'sh8000;
        end else begin
            tg_val = tg_q[15:0];
        end
    end

    // Integrator update with saturation and the clamped drive.
    always_comb begin
        pi_sum = SUM_W'($signed(r_prod[29:0])) + SUM_W'(cur_i);
        if (pi_sum > SUM_W'(34'sh07fffffff)) begin
            integ_sat = 32'sh7fffffff;
        end else if (pi_sum < -SUM_W'(34'sh080000000)) begin
            integ_sat = 32'sh80000000;
        end else begin
            integ_sat = pi_sum[31:0];
        end
        pi_b   = pi_sum + ((pi_sum < 0) ? DRV_BIAS : '0);
        pi_d   = pi_b >>> GAIN_FRAC_BITS;
        pi_lim = $signed({24'b0, r_lim});
        if (pi_d >= pi_lim) begin
            drv_val = pi_lim[10:0];
        end else if (pi_d <= -pi_lim) begin
            drv_val = -(pi_lim[10:0]);
        end else begin
            drv_val = pi_d[10:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= owpi_pkg::KP_RST;
            r_ki    <= owpi_pkg::KI_RST;
            r_ratio <= owpi_pkg::RATIO_RST;
            r_lim   <= owpi_pkg::LIM_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                owpi_pkg::REG_KP:    r_kp    <= i_cfg_data[owpi_pkg::GAIN_W-1:0];
                owpi_pkg::REG_KI:    r_ki    <= i_cfg_data[owpi_pkg::GAIN_W-1:0];
                owpi_pkg::REG_RATIO: r_ratio <= i_cfg_data;
                owpi_pkg::REG_LIM:   r_lim   <= i_cfg_data[owpi_pkg::LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Wheel state: targets and integrators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_target[k] <= '0;
                r_integ[k]  <= '0;
            end
        end else begin
            case (i_cmd.op)
                owpi_pkg::OP_TG_STORE: r_target[i_cmd.wheel] <= tg_val;
                owpi_pkg::OP_PI_ERR: begin
                    // Clear the integrator when the target is zero or its sign opposes it.
                    if ((cur_i > 0 && cur_t <= 0) || (cur_i < 0 && cur_t >= 0)) begin
                        r_integ[i_cmd.wheel] <= '0;
                    end
                end
                owpi_pkg::OP_PI_INTEG: r_integ[i_cmd.wheel] <= integ_sat;
                default: begin
                end
            endcase
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            owpi_pkg::OP_LOAD: begin
                r_x      <= i_vel_x;
                r_y      <= i_vel_y;
                r_mx     <= owpi_pkg::MAP_W'(i_vel_x);
                r_my     <= owpi_pkg::MAP_W'(i_vel_y);
                r_rot    <= i_vel_rot;
                r_circle <= i_circle_mode;
                r_enc[0] <= i_enc_count_0;
                r_enc[1] <= i_enc_count_1;
                r_enc[2] <= i_enc_count_2;
                r_enc[3] <= i_enc_count_3;
            end
            owpi_pkg::OP_ROT: r_rotp <= mul_p[35:0];
            owpi_pkg::OP_SQ_INIT: begin
                r_sq_a   <= (sq_diff < 0) ? '0 : sq_diff[30:0];
                r_sq_r   <= '0;
                r_sq_bit <= 31'd1 << 30;
            end
            owpi_pkg::OP_SQ_STEP: begin
                if ({1'b0, r_sq_a} >= sq_rb) begin
                    r_sq_a <= r_sq_a - sq_rb[30:0];
                    r_sq_r <= (r_sq_r >> 1) + {1'b0, r_sq_bit};
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            owpi_pkg::OP_SQ_MUL,
            owpi_pkg::OP_TG_MUL1,
            owpi_pkg::OP_TG_MUL2,
            owpi_pkg::OP_PI_MULI,
            owpi_pkg::OP_PI_MULP: r_prod <= mul_p;
            owpi_pkg::OP_SQ_STORE: begin
                if (i_cmd.axis) begin
                    r_my <= map_b[owpi_pkg::MAP_SHIFT +: owpi_pkg::MAP_W];
                end else begin
                    r_mx <= map_b[owpi_pkg::MAP_SHIFT +: owpi_pkg::MAP_W];
                end
            end
            owpi_pkg::OP_PI_ERR: begin
                r_err <= owpi_pkg::ERR_W'(cur_t) - owpi_pkg::ERR_W'(r_enc[i_cmd.wheel]);
            end
            owpi_pkg::OP_PI_DRIVE: r_drive[i_cmd.wheel] <= drv_val;
            default: begin
            end
        endcase
    end

    // Output register, free again once the receiver takes the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == owpi_pkg::OP_PUBLISH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == owpi_pkg::OP_PUBLISH) begin
            for (int k = 0; k < 4; k++) begin
                r_out[k] <= r_drive[k];
            end
        end
    end

    assign o_stat.circle   = r_circle;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_drive_0       = r_out[0];
    assign o_drive_1       = r_out[1];
    assign o_drive_2       = r_out[2];
    assign o_drive_3       = r_out[3];

endmodule

// ----- rtl/core/omni_wheel_velocity_pi_controller_core.sv -----
// Top level of the omni wheel PI controller: controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready) takes one request per item. A
// command request (func 0) maps the body velocities to four wheel targets
// and gives no result. A tick request (func 1) runs the PI loop for all
// four wheels and gives one result request on o_out_valid / i_out_ready.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready and
// writes the gain, ratio and limit registers; write only while idle.
// A tick computes the error, integral product, integrator, proportional
// product and drive for each wheel in turn, then publishes the result; a
// command computes the rotation product, with circle mapping runs the
// 16-step square root unit once per axis, then two products on the single
// shared multiplier and a store per wheel. One item is in work at a time.
// The finished result sits in an output register, so the receiver may stall
// while the next item is accepted; a tick finishing into a full output
// register waits until it is taken.
// A synchronous active-low reset clears targets, integrators and registers
// to their reset values; the block is ready in the first cycle after.
module omni_wheel_velocity_pi_controller_core #(
    parameter int GAIN_FRAC_BITS = owpi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic signed [owpi_pkg::VEL_W-1:0] i_vel_x,
    input  logic signed [owpi_pkg::VEL_W-1:0] i_vel_y,
    input  logic signed [owpi_pkg::ROT_W-1:0] i_vel_rot,
    input  logic                              i_circle_mode,
    input  logic signed [owpi_pkg::ENC_W-1:0] i_enc_count_0,
    input  logic signed [owpi_pkg::ENC_W-1:0] i_enc_count_1,
    input  logic signed [owpi_pkg::ENC_W-1:0] i_enc_count_2,
    input  logic signed [owpi_pkg::ENC_W-1:0] i_enc_count_3,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [owpi_pkg::DRV_W-1:0] o_drive_0,
    output logic signed [owpi_pkg::DRV_W-1:0] o_drive_1,
    output logic signed [owpi_pkg::DRV_W-1:0] o_drive_2,
    output logic signed [owpi_pkg::DRV_W-1:0] o_drive_3,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [owpi_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [owpi_pkg::CFG_W-1:0]        i_cfg_data
);

    owpi_pkg::t_cmd  cmd;
    owpi_pkg::t_stat stat;

    // Configuration writes are taken at once.
    assign o_cfg_ready = 1'b1;

    // Sequencer.
    owpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    owpi_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_vel_rot     (i_vel_rot),
        .i_circle_mode (i_circle_mode),
        .i_enc_count_0 (i_enc_count_0),
        .i_enc_count_1 (i_enc_count_1),
        .i_enc_count_2 (i_enc_count_2),
        .i_enc_count_3 (i_enc_count_3),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_drive_0     (o_drive_0),
        .o_drive_1     (o_drive_1),
        .o_drive_2     (o_drive_2),
        .o_drive_3     (o_drive_3)
    );

endmodule
